// ===== sv/separable_gaussian_blur_rgb_unit_assert.svh =====
// Assertion macros used by the blur unit's vertical filter RTL.
// SGB_ASSERT_IMP: antecedent implies consequent in the same cycle.
// SGB_ASSERT_NXT: antecedent implies consequent in the next cycle.
`ifndef SEPARABLE_GAUSSIAN_BLUR_RGB_UNIT_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_RGB_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blur unit: same-cycle check failed");
`define SGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blur unit: next-cycle check failed");
`else
`define SGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/sgb_pkg.sv =====
`timescale 1ns / 1ps
package sgb_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int TAPS        = 9;
    localparam int HALF        = (TAPS - 1) / 2;
    localparam int SLOTS       = TAPS - 1;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int FIELD_LIMIT = 1024;
    localparam int WIDTH_TOP   = (MAX_WIDTH < FIELD_LIMIT) ? MAX_WIDTH : FIELD_LIMIT;
    localparam int MEM_AW      = $clog2(MAX_WIDTH);

    localparam int CNT_W       = 11;
    localparam int POS_W       = 10;
    localparam int PIX_W       = 16;
    localparam int HACC_W      = 24;
    localparam int HSUM_W      = 20;
    localparam int ROUND_SHIFT = 12;
    localparam int VSUM_W      = PIX_W + ROUND_SHIFT;
    localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
    localparam int WGT_W       = 7;

    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam logic [CNT_W-1:0] FRAME_DIM_RESET = 11'd512;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb_pix;

    typedef struct packed {
        logic [HSUM_W-1:0] red;
        logic [HSUM_W-1:0] green;
        logic [HSUM_W-1:0] blue;
    } t_rgb_hsum;

    // one line store word: the horizontal sums of all row slots at one column
    typedef t_rgb_hsum [SLOTS-1:0] t_line_word;

    typedef struct packed {
        t_rgb_hsum         hsum;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic              has_col;
        logic              has_out;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic [SLOTS-1:0]  mask;
    } t_hitem;

    typedef struct packed {
        t_rgb_pix         pix;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } t_result;

    function automatic logic [WGT_W-1:0] f_weight(input int idx);
        case (idx)
            0, 8:    return 7'd1;
            1, 7:    return 7'd8;
            2, 6:    return 7'd28;
            3, 5:    return 7'd56;
            4:       return 7'd70;
            default: return 7'd0;
        endcase
    endfunction

endpackage

// ===== sv/sgb_hfilter.sv =====
`timescale 1ns / 1ps
module sgb_hfilter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [sgb_pkg::CNT_W-1:0]  i_frame_width,
    input  logic [sgb_pkg::CNT_W-1:0]  i_frame_height,
    input  logic                       i_opcode,
    input  sgb_pkg::t_rgb_pix          i_pix,
    output sgb_pkg::t_hitem            o_item
);
    import sgb_pkg::*;

    logic [CNT_W-1:0] r_col_cnt, n_col_cnt;
    logic [CNT_W-1:0] r_row_cnt, n_row_cnt;
    t_rgb_pix         r_window [SLOTS];
    logic [CNT_W-1:0] used_w, used_h;
    logic [CNT_W-1:0] x_inc, y_inc, col_ext, row_ext;
    logic             real_pix, has_col;
    t_rgb_pix         sample;
    logic [TAPS-1:0][PIX_W-1:0] taps_red, taps_green, taps_blue;

    function automatic logic [CNT_W-1:0] f_clamp(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] top);
        if (v == '0)
            return CNT_W'(1);
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic logic [HSUM_W-1:0] f_hsum(input logic [TAPS-1:0][PIX_W-1:0] taps);
        logic [HACC_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
            acc = acc + HACC_W'(taps[i]) * HACC_W'(f_weight(i));
        return acc[HACC_W-1 -: HSUM_W];
    endfunction

    always_comb begin
        used_w   = f_clamp(i_frame_width, CNT_W'(WIDTH_TOP));
        used_h   = f_clamp(i_frame_height, CNT_W'(FIELD_LIMIT));
        real_pix = (i_opcode == OP_PIXEL) && (r_col_cnt < used_w) && (r_row_cnt < used_h);
        sample   = real_pix ? i_pix : '0;

        for (int i = 0; i < SLOTS; i++) begin
            taps_red[i]   = r_window[i].red;
            taps_green[i] = r_window[i].green;
            taps_blue[i]  = r_window[i].blue;
        end
        taps_red[TAPS-1]   = sample.red;
        taps_green[TAPS-1] = sample.green;
        taps_blue[TAPS-1]  = sample.blue;

        col_ext = r_col_cnt - CNT_W'(HALF);
        row_ext = r_row_cnt - CNT_W'(HALF);
        has_col = (r_col_cnt >= CNT_W'(HALF)) && (r_col_cnt < used_w + CNT_W'(HALF));

        o_item.hsum.red   = f_hsum(taps_red);
        o_item.hsum.green = f_hsum(taps_green);
        o_item.hsum.blue  = f_hsum(taps_blue);
        o_item.col        = col_ext[POS_W-1:0];
        o_item.row        = row_ext[POS_W-1:0];
        o_item.has_col    = has_col;
        o_item.has_out    = has_col && (r_row_cnt >= CNT_W'(HALF))
                            && (r_row_cnt < used_h + CNT_W'(HALF));
        o_item.last       = (col_ext == used_w - 1'b1) && (row_ext == used_h - 1'b1);
        o_item.slot       = r_row_cnt[SLOT_W-1:0];
        // rows above the frame top read as zero, whatever the store holds
        for (int i = 0; i < SLOTS; i++)
            o_item.mask[i] = ((CNT_W+1)'(r_row_cnt) + (CNT_W+1)'(i)) >= (CNT_W+1)'(SLOTS);

        x_inc = r_col_cnt + 1'b1;
        y_inc = r_row_cnt + 1'b1;
        n_col_cnt = x_inc;
        n_row_cnt = r_row_cnt;
        if (x_inc >= used_w + CNT_W'(HALF)) begin
            n_col_cnt = '0;
            n_row_cnt = (y_inc >= used_h + CNT_W'(HALF)) ? '0 : y_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (i_accept) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // window entry 0 is the oldest sample; restart empty at each row start
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < SLOTS - 1; i++)
                r_window[i] <= (r_col_cnt == '0) ? '0 : r_window[i+1];
            r_window[SLOTS-1] <= sample;
        end
    end

endmodule

// ===== sv/sgb_vfilter.sv =====
`timescale 1ns / 1ps
`include "separable_gaussian_blur_rgb_unit_assert.svh"
module sgb_vfilter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_advance,
    input  sgb_pkg::t_hitem    i_item,
    output logic               o_valid,
    output logic               o_has_out,
    output sgb_pkg::t_result   o_result
);
    import sgb_pkg::*;

    t_line_word r_line_mem [MAX_WIDTH];
    t_line_word r_rdata;
    t_line_word wdata;
    t_hitem     r_a;
    logic       r_a_valid;
    logic       write_en;
    logic [SLOTS-1:0][HSUM_W-1:0] rows_red, rows_green, rows_blue;

    function automatic logic [PIX_W-1:0] f_vround(input logic [SLOTS-1:0][HSUM_W-1:0] rows,
                                                  input logic [HSUM_W-1:0]  hnow,
                                                  input logic [SLOT_W-1:0]  slot,
                                                  input logic [SLOTS-1:0]   mask);
        logic [VSUM_W-1:0] acc;
        logic [SLOT_W-1:0] s;
        acc = VSUM_W'(hnow) + VSUM_W'(ROUND_HALF);
        for (int i = 0; i < SLOTS; i++) begin
            s = slot + SLOT_W'(i);
            if (mask[i])
                acc = acc + VSUM_W'(rows[s]) * VSUM_W'(f_weight(i));
        end
        return acc[VSUM_W-1 -: PIX_W];
    endfunction

    // a column comes back at least five transfers later, so the write of
    // one item always lands before the next read of the same entry
    always_ff @(posedge i_clk) begin
        if (i_accept && i_item.has_col)
            r_rdata <= r_line_mem[MEM_AW'(i_item.col)];
        if (write_en)
            r_line_mem[MEM_AW'(r_a.col)] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_a_valid <= 1'b0;
        else if (i_accept)
            r_a_valid <= 1'b1;
        else if (i_advance)
            r_a_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept)
            r_a <= i_item;
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            rows_red[i]   = r_rdata[i].red;
            rows_green[i] = r_rdata[i].green;
            rows_blue[i]  = r_rdata[i].blue;
        end
        // replace the oldest row of this slot with the current row's sum
        wdata           = r_rdata;
        wdata[r_a.slot] = r_a.hsum;
        write_en        = i_advance && r_a.has_col;

        o_result.pix.red   = f_vround(rows_red,   r_a.hsum.red,   r_a.slot, r_a.mask);
        o_result.pix.green = f_vround(rows_green, r_a.hsum.green, r_a.slot, r_a.mask);
        o_result.pix.blue  = f_vround(rows_blue,  r_a.hsum.blue,  r_a.slot, r_a.mask);
        o_result.col       = r_a.col;
        o_result.row       = r_a.row;
        o_result.last      = r_a.last;
    end

    assign o_valid   = r_a_valid;
    assign o_has_out = r_a.has_out;

    `SGB_ASSERT_IMP(a_no_rw_same_col, i_clk, i_rst_n, write_en && i_accept && i_item.has_col, i_item.col != r_a.col)
    `SGB_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_accept && r_a_valid, i_advance)
    `SGB_ASSERT_IMP(a_advance_needs_item, i_clk, i_rst_n, i_advance, r_a_valid)

endmodule

// ===== sv/separable_gaussian_blur_rgb_unit.sv =====
`timescale 1ns / 1ps
// Separable 9-tap Gaussian blur on an RGB raster stream (Q4.12 components).
// Input channel i_valid/o_stall: send (width+4) x (height+4) items in raster
// order; positions beyond the frame are drain items (i_opcode high, or any
// item there). One transfer per clock is sustained while the output is not stalled.
// Output channel o_valid/i_stall: the blurred pixel (x-4, y-4) is produced by
// the transfer of extended position (x, y); its result is registered in the
// vertical stage and then in the output register, which drives o_valid.
// Items with no result leave nothing on the output.
// Rate is one item per cycle while the output is not stalled, set by the line
// store's single read port and single write port, each used at most once per item.
// While the receiver stalls, one result waits in the output register and one
// item in the vertical stage; then o_stall rises until the output is taken.
// Reset (synchronous, i_rst_n low) zeroes the position counters and sets both
// frame dimensions to 512. The line store is not cleared: rows above the frame
// top are masked off, so no clearing pass is needed.
// APB registers: 0x0 frame_width, 0x4 frame_height (11 bits, read back).
// Write them only while no item is in flight.
module separable_gaussian_blur_rgb_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_opcode,
    input  logic [sgb_pkg::PIX_W-1:0]   i_in_red,
    input  logic [sgb_pkg::PIX_W-1:0]   i_in_green,
    input  logic [sgb_pkg::PIX_W-1:0]   i_in_blue,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sgb_pkg::PIX_W-1:0]   o_out_red,
    output logic [sgb_pkg::PIX_W-1:0]   o_out_green,
    output logic [sgb_pkg::PIX_W-1:0]   o_out_blue,
    output logic [sgb_pkg::POS_W-1:0]   o_out_column,
    output logic [sgb_pkg::POS_W-1:0]   o_out_row,
    output logic                        o_last_of_frame,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sgb_pkg::ADDR_W-1:0]  paddr,
    input  logic [sgb_pkg::DATA_W-1:0]  pwdata,
    output logic [sgb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import sgb_pkg::*;

    logic [CNT_W-1:0] r_frame_width, r_frame_height;
    logic             r_b_valid;
    t_result          r_b;
    logic             accept, advance, a_ready, b_ready;
    logic             a_valid, a_has_out, cfg_write;
    t_reg_idx         reg_idx;
    t_rgb_pix         in_pix;
    t_hitem           h_item;
    t_result          a_result;

    assign b_ready = !r_b_valid || !i_stall;
    assign a_ready = !a_valid || b_ready;
    assign o_stall = !a_ready;
    assign accept  = i_valid && a_ready;
    assign advance = a_valid && b_ready;

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;

    sgb_hfilter u_hfilter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_opcode       (i_opcode),
        .i_pix          (in_pix),
        .o_item         (h_item)
    );

    sgb_vfilter u_vfilter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_advance (advance),
        .i_item    (h_item),
        .o_valid   (a_valid),
        .o_has_out (a_has_out),
        .o_result  (a_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_b_valid <= 1'b0;
        else if (b_ready)
            r_b_valid <= advance && a_has_out;
    end

    always_ff @(posedge i_clk) begin
        if (advance && a_has_out)
            r_b <= a_result;
    end

    assign o_valid         = r_b_valid;
    assign o_out_red       = r_b.pix.red;
    assign o_out_green     = r_b.pix.green;
    assign o_out_blue      = r_b.pix.blue;
    assign o_out_column    = r_b.col;
    assign o_out_row       = r_b.row;
    assign o_last_of_frame = r_b.last;

    // register index is the word address; byte offset bits are ignored
    assign reg_idx   = t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_DIM_RESET;
            r_frame_height <= FRAME_DIM_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CNT_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

endmodule
